// ===== design/eg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eg_pkg
// Shared widths, codes, reset values and handshake types of the
// epsilon-greedy action learner.
// ----------------------------------------------------------------------------
package eg_pkg;

    localparam int MAX_ACTIONS_DEF = 8;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int OP_W       = 2;
    localparam int REWARD_W   = 16;
    localparam int PCT_W      = 7;
    localparam int PICK_W     = 8;
    localparam int LR_W       = 16;
    localparam int CNT_W      = 4;
    localparam int ACTION_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROUND_HALF = 1 << (LR_W - 1);

    localparam logic [OP_W-1:0] OP_COLLECT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SELECT  = 2'd2;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NO_REWARD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLOIT_PCT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_ENABLE = 2'd3;

    localparam logic [LR_W-1:0]  LEARN_RATE_RST   = 16'd6554;
    localparam logic [PCT_W-1:0] EXPLOIT_PCT_RST  = 7'd80;
    localparam logic [CNT_W-1:0] ACTION_COUNT_RST = 4'd3;
    localparam logic             BOOST_ENABLE_RST = 1'b1;

    typedef struct packed {
        logic              start;
        logic [PICK_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } mod_rsp_t;

endpackage

// ===== design/eg_est_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eg_est_mem
// Estimate store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module eg_est_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/eg_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eg_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module eg_mod_unit
    import eg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int STEP_W = $clog2(PICK_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PICK_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PICK_W-1:0] div_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  rem_reg;

    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] rem_next;

    always_comb
    begin
        trial = {rem_reg, div_reg[PICK_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = CNT_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            div_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                div_reg  <= req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                div_reg  <= {div_reg[PICK_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/epsilon_greedy_action_learner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_greedy_action_learner_unit
// Epsilon-greedy bandit learner: estimates in a one-port-read memory,
// read-modify-write update, scanned argmax with modulo tie pick.
//
//   channel | signals                                        | dir
//   in      | in_valid in_ready operation reward_value       | in
//           | random_percent random_pick                     |
//   out     | out_valid out_ready chosen_action boost_armed  | out
//           | reward_waiting status                          |
//   cfg     | cfg_write cfg_index cfg_data                   | in
//
// One word at a time. Collect, update without reward and boosted select
// go straight to the result. Update: memory read, multiply, write back.
// Explore: 8-step remainder unit. Exploit: two memory scans over the N
// actions in use, then the remainder and the tie walk.
// Reset is asynchronous; no clearing pass. A held result stalls only at the
// end of the next word's work.
// ----------------------------------------------------------------------------
module epsilon_greedy_action_learner_unit
    import eg_pkg::*;
#(
    parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [REWARD_W-1:0] reward_value,
    input  logic [PCT_W-1:0]           random_percent,
    input  logic [PICK_W-1:0]          random_pick,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ACTION_W-1:0]        chosen_action,
    output logic                       boost_armed,
    output logic                       reward_waiting,
    output logic                       status
);

    localparam int IDX_W = $clog2(MAX_ACTIONS);
    localparam int CW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int DW    = ((VALUE_BITS > REWARD_W) ? VALUE_BITS : REWARD_W) + 1;
    localparam int PW    = DW + LR_W + 1;

    localparam logic signed [DW-1:0] HI_D = {{(DW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [DW-1:0] LO_D = {{(DW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] HI_P = {{(PW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] LO_P = {{(PW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_P = PW'(ROUND_HALF);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DONE    = 4'd1;
    localparam logic [3:0] S_UPD_RD  = 4'd2;
    localparam logic [3:0] S_UPD_MUL = 4'd3;
    localparam logic [3:0] S_UPD_WR  = 4'd4;
    localparam logic [3:0] S_MAX     = 4'd5;
    localparam logic [3:0] S_TIE     = 4'd6;
    localparam logic [3:0] S_MOD     = 4'd7;
    localparam logic [3:0] S_PICK    = 4'd8;

    // configuration
    logic [LR_W-1:0]  learn_rate_reg;
    logic [PCT_W-1:0] exploit_pct_reg;
    logic [CNT_W-1:0] action_count_reg;
    logic             boost_enable_reg;

    // learner state
    logic [3:0]                 state_reg;
    logic [MAX_ACTIONS-1:0]     unset_reg;
    logic [IDX_W-1:0]           choice_reg;
    logic                       boost_reg;
    logic signed [REWARD_W-1:0] reward_reg;
    logic                       fresh_reg;
    logic                       status_pend_reg;

    // scan and pick
    logic [IDX_W-1:0]             scan_idx_reg;
    logic                         issue_on_reg;
    logic                         rd_vld_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic signed [VALUE_BITS-1:0] top_reg;
    logic [MAX_ACTIONS-1:0]       tie_mask_reg;
    logic [CNT_W-1:0]             ties_reg;
    logic [PICK_W-1:0]            pick_reg;
    logic                         explore_reg;
    logic [CNT_W-1:0]             want_reg;
    logic [IDX_W-1:0]             pidx_reg;

    // update datapath
    logic signed [PW-1:0]         prod_reg;
    logic signed [VALUE_BITS-1:0] est_reg;

    // output word
    logic                out_valid_reg;
    logic [ACTION_W-1:0] action_out_reg;
    logic                boost_out_reg;
    logic                fresh_out_reg;
    logic                status_out_reg;

    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       n_last;
    logic [MAX_ACTIONS-1:0] inuse;
    logic                   starting;
    logic                   exploit;
    logic                   in_accept;

    logic                         mem_rd_en;
    logic [IDX_W-1:0]             mem_rd_addr;
    logic [VALUE_BITS-1:0]        mem_rd_data;
    logic signed [VALUE_BITS-1:0] mem_q;
    logic                         mem_wr_en;
    logic [VALUE_BITS-1:0]        mem_wr_data;

    logic signed [DW-1:0]         rew_x;
    logic signed [VALUE_BITS-1:0] rew_sat;
    logic signed [VALUE_BITS-1:0] est_now;
    logic signed [DW-1:0]         est_x;
    logic signed [DW-1:0]         diff;
    logic signed [LR_W:0]         lr_s;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         rnd_sum;
    logic signed [PW-1:0]         delta;
    logic signed [PW-1:0]         new_sum;
    logic signed [VALUE_BITS-1:0] new_sat;

    logic             issue_last;
    logic             rd_last;
    logic             tie_hit;
    logic [CNT_W-1:0] ties_inc;

    mod_req_t mod_req;
    mod_rsp_t mod_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (action_count_reg == '0)
        begin
            n_eff = 4'd1;
        end
        else if (32'(action_count_reg) > MAX_ACTIONS)
        begin
            n_eff = CNT_W'(MAX_ACTIONS);
        end
        else
        begin
            n_eff = action_count_reg;
        end
        n_last = n_eff - 1'b1;
        for (int i = 0; i < MAX_ACTIONS; i++)
        begin
            inuse[i] = (i < 32'(n_eff));
        end
        starting = |(unset_reg & inuse);
        exploit  = (random_percent < exploit_pct_reg) && !starting;
    end

    assign issue_last = (CW'(scan_idx_reg) == CW'(n_last));
    assign rd_last    = (CW'(rd_idx_reg) == CW'(n_last));
    assign mem_q      = $signed(mem_rd_data);
    assign tie_hit    = (mem_q == top_reg);
    assign ties_inc   = ties_reg + CNT_W'(tie_hit);

    assign mem_rd_en   = (state_reg == S_UPD_RD) ||
                         (((state_reg == S_MAX) || (state_reg == S_TIE)) && issue_on_reg);
    assign mem_rd_addr = (state_reg == S_UPD_RD) ? choice_reg : scan_idx_reg;
    assign mem_wr_en   = (state_reg == S_UPD_WR);
    assign mem_wr_data = new_sat;

    // update arithmetic
    always_comb
    begin
        rew_x = {{(DW-REWARD_W){reward_reg[REWARD_W-1]}}, reward_reg};
        if (rew_x > HI_D)
        begin
            rew_sat = HI_D[VALUE_BITS-1:0];
        end
        else if (rew_x < LO_D)
        begin
            rew_sat = LO_D[VALUE_BITS-1:0];
        end
        else
        begin
            rew_sat = rew_x[VALUE_BITS-1:0];
        end
        est_now = unset_reg[choice_reg] ? rew_sat : mem_q;
        est_x   = {{(DW-VALUE_BITS){est_now[VALUE_BITS-1]}}, est_now};
        diff    = rew_x - est_x;
        lr_s    = {1'b0, learn_rate_reg};
        prod    = PW'(lr_s) * PW'(diff);

        rnd_sum = prod_reg + ROUND_P;
        delta   = rnd_sum >>> LR_W;
        new_sum = {{(PW-VALUE_BITS){est_reg[VALUE_BITS-1]}}, est_reg} + delta;
        if (new_sum > HI_P)
        begin
            new_sat = HI_P[VALUE_BITS-1:0];
        end
        else if (new_sum < LO_P)
        begin
            new_sat = LO_P[VALUE_BITS-1:0];
        end
        else
        begin
            new_sat = new_sum[VALUE_BITS-1:0];
        end
    end

    always_comb
    begin
        mod_req.start    = 1'b0;
        mod_req.dividend = random_pick;
        mod_req.divisor  = n_eff;
        if (in_accept && (operation == OP_SELECT) && !boost_reg && !exploit)
        begin
            mod_req.start = 1'b1;
        end
        else if ((state_reg == S_TIE) && rd_vld_reg && rd_last)
        begin
            mod_req.start    = 1'b1;
            mod_req.dividend = pick_reg;
            mod_req.divisor  = ties_inc;
        end
    end

    eg_est_mem #(
        .DEPTH  (MAX_ACTIONS),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (choice_reg),
        .wr_data (mem_wr_data)
    );

    eg_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg   <= LEARN_RATE_RST;
            exploit_pct_reg  <= EXPLOIT_PCT_RST;
            action_count_reg <= ACTION_COUNT_RST;
            boost_enable_reg <= BOOST_ENABLE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LEARN_RATE:   learn_rate_reg   <= cfg_data[LR_W-1:0];
                CFG_EXPLOIT_PCT:  exploit_pct_reg  <= cfg_data[PCT_W-1:0];
                CFG_ACTION_COUNT: action_count_reg <= cfg_data[CNT_W-1:0];
                CFG_BOOST_ENABLE: boost_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            unset_reg       <= '1;
            choice_reg      <= '0;
            boost_reg       <= 1'b0;
            reward_reg      <= '0;
            fresh_reg       <= 1'b0;
            status_pend_reg <= ST_OK;
            scan_idx_reg    <= '0;
            issue_on_reg    <= 1'b0;
            rd_vld_reg      <= 1'b0;
            rd_idx_reg      <= '0;
            top_reg         <= '0;
            tie_mask_reg    <= '0;
            ties_reg        <= '0;
            pick_reg        <= '0;
            explore_reg     <= 1'b0;
            want_reg        <= '0;
            pidx_reg        <= '0;
            prod_reg        <= '0;
            est_reg         <= '0;
            out_valid_reg   <= 1'b0;
            action_out_reg  <= '0;
            boost_out_reg   <= 1'b0;
            fresh_out_reg   <= 1'b0;
            status_out_reg  <= ST_OK;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            rd_vld_reg <= mem_rd_en && (state_reg != S_UPD_RD);
            rd_idx_reg <= scan_idx_reg;
            if (((state_reg == S_MAX) || (state_reg == S_TIE)) && issue_on_reg)
            begin
                if (issue_last)
                begin
                    issue_on_reg <= 1'b0;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        pick_reg <= random_pick;
                        case (operation)
                            OP_COLLECT:
                            begin
                                reward_reg      <= reward_value;
                                fresh_reg       <= 1'b1;
                                status_pend_reg <= ST_OK;
                                state_reg       <= S_DONE;
                            end
                            OP_UPDATE:
                            begin
                                if (!fresh_reg)
                                begin
                                    status_pend_reg <= ST_NO_REWARD;
                                    state_reg       <= S_DONE;
                                end
                                else
                                begin
                                    status_pend_reg <= ST_OK;
                                    state_reg       <= S_UPD_RD;
                                end
                            end
                            OP_SELECT:
                            begin
                                status_pend_reg <= ST_OK;
                                if (boost_reg)
                                begin
                                    boost_reg <= 1'b0;
                                    state_reg <= S_DONE;
                                end
                                else if (exploit)
                                begin
                                    scan_idx_reg <= '0;
                                    issue_on_reg <= 1'b1;
                                    state_reg    <= S_MAX;
                                end
                                else
                                begin
                                    explore_reg <= 1'b1;
                                    state_reg   <= S_MOD;
                                end
                            end
                            default:
                            begin
                                status_pend_reg <= ST_OK;
                                state_reg       <= S_DONE;
                            end
                        endcase
                    end
                end
                S_UPD_RD:
                begin
                    state_reg <= S_UPD_MUL;
                end
                S_UPD_MUL:
                begin
                    prod_reg              <= prod;
                    est_reg               <= est_now;
                    unset_reg[choice_reg] <= 1'b0;
                    fresh_reg             <= 1'b0;
                    if (boost_enable_reg && (rew_x > est_x))
                    begin
                        boost_reg <= 1'b1;
                    end
                    state_reg <= S_UPD_WR;
                end
                S_UPD_WR:
                begin
                    state_reg <= S_DONE;
                end
                S_MAX:
                begin
                    if (rd_vld_reg)
                    begin
                        if ((rd_idx_reg == '0) || (mem_q > top_reg))
                        begin
                            top_reg <= mem_q;
                        end
                        if (rd_last)
                        begin
                            scan_idx_reg <= '0;
                            issue_on_reg <= 1'b1;
                            ties_reg     <= '0;
                            tie_mask_reg <= '0;
                            state_reg    <= S_TIE;
                        end
                    end
                end
                S_TIE:
                begin
                    if (rd_vld_reg)
                    begin
                        if (tie_hit)
                        begin
                            tie_mask_reg[rd_idx_reg] <= 1'b1;
                        end
                        ties_reg <= ties_inc;
                        if (rd_last)
                        begin
                            explore_reg <= 1'b0;
                            state_reg   <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_rsp.done)
                    begin
                        if (explore_reg)
                        begin
                            choice_reg <= IDX_W'(mod_rsp.rem);
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            want_reg  <= mod_rsp.rem;
                            pidx_reg  <= '0;
                            state_reg <= S_PICK;
                        end
                    end
                end
                S_PICK:
                begin
                    pidx_reg <= pidx_reg + 1'b1;
                    if (tie_mask_reg[pidx_reg])
                    begin
                        if (want_reg == '0)
                        begin
                            choice_reg <= pidx_reg;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            want_reg <= want_reg - 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        action_out_reg <= ACTION_W'(choice_reg);
                        boost_out_reg  <= boost_reg;
                        fresh_out_reg  <= fresh_reg;
                        status_out_reg <= status_pend_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign chosen_action  = action_out_reg;
    assign boost_armed    = boost_out_reg;
    assign reward_waiting = fresh_out_reg;
    assign status         = status_out_reg;

endmodule

// ===== design/eg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eg_checker
// Port-level checks of the learner: output hold, one word in flight,
// status consistency.
// ----------------------------------------------------------------------------
module eg_checker
    import eg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [ACTION_W-1:0] chosen_action,
    input logic                boost_armed,
    input logic                reward_waiting,
    input logic                status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(chosen_action) && $stable(boost_armed) &&
        $stable(reward_waiting) && $stable(status))
        else $error("output word changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in work");

    a_status_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_REWARD) |-> !reward_waiting)
        else $error("no-reward status with a reward waiting");

endmodule

bind epsilon_greedy_action_learner_unit eg_checker u_eg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .chosen_action  (chosen_action),
    .boost_armed    (boost_armed),
    .reward_waiting (reward_waiting),
    .status         (status)
);
